// ----- sv/running_kth_nearest_point_defines.svh -----
// Assertion macros for the running K-th nearest point block.
`ifndef RUNNING_KTH_NEAREST_POINT_DEFINES_SVH
`define RUNNING_KTH_NEAREST_POINT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define RKN_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("running_kth_nearest_point: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define RKN_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("running_kth_nearest_point: next-cycle check failed");

`endif

// ----- sv/rkn_pkg.sv -----
// Package with constants and payload types of the running K-th nearest point block.
package rkn_pkg;

  localparam int MAX_RANK   = 16;
  localparam int COORD_BITS = 16;
  localparam int DIST_BITS  = 2 * COORD_BITS;
  localparam int CNT_BITS   = $clog2(MAX_RANK + 1);
  localparam int IDX_BITS   = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
  localparam int RANK_BITS  = 5;
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_BITS  = $clog2(FIFO_DEPTH);
  localparam int FCNT_BITS  = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic                         want_report;
    logic                         start_set;
  } in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] kth_x;
    logic signed [COORD_BITS-1:0] kth_y;
    logic                         result_valid;
  } out_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic        [DIST_BITS-1:0]  dist_sq;
    logic                         want_report;
    logic                         start_set;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ----- sv/rkn_front.sv -----
// Front stage: accepts points and computes their squared distance.
module rkn_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rkn_pkg::in_t   in_data_i,
  input  rkn_pkg::fifo_stat_t fifo_stat_i,
  output logic           push_o,
  output rkn_pkg::entry_t push_data_o
);
  import rkn_pkg::*;

  logic   valid_q, valid_d;
  entry_t entry_q;
  logic   accept;
  logic signed [DIST_BITS-1:0] xx, yy;

  assign push_o      = valid_q && !fifo_stat_i.full;
  assign in_stall_o  = valid_q && fifo_stat_i.full;
  assign accept      = in_valid_i && !in_stall_o;
  assign push_data_o = entry_q;

  always_comb begin
    xx = in_data_i.point_x * in_data_i.point_x;
    yy = in_data_i.point_y * in_data_i.point_y;
    if (accept) begin
      valid_d = 1'b1;
    end else if (push_o) begin
      valid_d = 1'b0;
    end else begin
      valid_d = valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q.x           <= in_data_i.point_x;
      entry_q.y           <= in_data_i.point_y;
      entry_q.dist_sq     <= unsigned'(xx) + unsigned'(yy);
      entry_q.want_report <= in_data_i.want_report;
      entry_q.start_set   <= in_data_i.start_set;
    end
  end

endmodule

// ----- sv/rkn_fifo.sv -----
// Short queue between the front stage and the sorted store.
module rkn_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  rkn_pkg::entry_t     push_data_i,
  input  logic                pop_i,
  output rkn_pkg::entry_t     head_o,
  output rkn_pkg::fifo_stat_t stat_o
);
  import rkn_pkg::*;

  entry_t                mem_q [FIFO_DEPTH];
  logic [FPTR_BITS-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FCNT_BITS-1:0]  cnt_q, cnt_d;
  logic                  do_push, do_pop;

  assign stat_o.full  = (int'(cnt_q) == FIFO_DEPTH);
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + FCNT_BITS'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - FCNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FPTR_BITS'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FPTR_BITS'(1);
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/rkn_back.sv -----
// Back stage: compare-and-shift sorted store and the result register.
module rkn_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [rkn_pkg::CNT_BITS-1:0] k_eff_i,
  input  rkn_pkg::entry_t      head_i,
  input  rkn_pkg::fifo_stat_t  fifo_stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output rkn_pkg::out_t        out_data_o
);
  import rkn_pkg::*;

  logic signed [COORD_BITS-1:0] xs_q [MAX_RANK];
  logic signed [COORD_BITS-1:0] ys_q [MAX_RANK];
  logic        [DIST_BITS-1:0]  ds_q [MAX_RANK];
  logic signed [COORD_BITS-1:0] xs_d [MAX_RANK];
  logic signed [COORD_BITS-1:0] ys_d [MAX_RANK];
  logic        [DIST_BITS-1:0]  ds_d [MAX_RANK];
  logic [CNT_BITS-1:0] cnt_q, cnt_d, cnt_eff;
  logic [MAX_RANK-1:0] ins;
  logic [IDX_BITS-1:0] kidx;
  logic  out_valid_q, out_valid_d;
  out_t  out_q, out_d;

  assign pop_o       = !fifo_stat_i.empty &&
                       (!head_i.want_report || !out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign kidx        = IDX_BITS'(k_eff_i - CNT_BITS'(1));

  always_comb begin
    logic lt;
    cnt_eff = head_i.start_set ? '0 : cnt_q;
    for (int i = 0; i < MAX_RANK; i++) begin
      lt = (head_i.dist_sq < ds_q[i]) ||
           ((head_i.dist_sq == ds_q[i]) &&
            ((head_i.x < xs_q[i]) || ((head_i.x == xs_q[i]) && (head_i.y < ys_q[i]))));
      ins[i] = (i >= int'(cnt_eff)) || lt;
    end
    for (int i = 0; i < MAX_RANK; i++) begin
      if (ins[i] && (i == 0 || !ins[(i == 0) ? 0 : i - 1])) begin
        xs_d[i] = head_i.x;
        ys_d[i] = head_i.y;
        ds_d[i] = head_i.dist_sq;
      end else if (ins[i]) begin
        xs_d[i] = xs_q[(i == 0) ? 0 : i - 1];
        ys_d[i] = ys_q[(i == 0) ? 0 : i - 1];
        ds_d[i] = ds_q[(i == 0) ? 0 : i - 1];
      end else begin
        xs_d[i] = xs_q[i];
        ys_d[i] = ys_q[i];
        ds_d[i] = ds_q[i];
      end
    end
    cnt_d = (int'(cnt_eff) < MAX_RANK) ? cnt_eff + CNT_BITS'(1) : cnt_eff;
    out_d.result_valid = (cnt_d >= k_eff_i);
    out_d.kth_x = out_d.result_valid ? xs_d[kidx] : '0;
    out_d.kth_y = out_d.result_valid ? ys_d[kidx] : '0;
    if (pop_o && head_i.want_report) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        cnt_q <= cnt_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      for (int i = 0; i < MAX_RANK; i++) begin
        xs_q[i] <= xs_d[i];
        ys_q[i] <= ys_d[i];
        ds_q[i] <= ds_d[i];
      end
      if (head_i.want_report) begin
        out_q <= out_d;
      end
    end
  end

endmodule

// ----- sv/running_kth_nearest_point.sv -----
// Top level of the running K-th nearest point block.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   in_data_i   (rkn_pkg::in_t)
//   result    out        out_valid_o / out_stall_i out_data_o  (rkn_pkg::out_t)
//   config    in         cfg_we_i                  cfg_wdata_i (k_rank)
//
// One point is accepted per cycle while the queue has room, and one is inserted into the
// sorted store per cycle unless a stalled result holds back a point wanting a report.
// A point is registered with its distance in the front stage, written into the queue,
// and then enters the store; the result register loads at the same edge as the insert.
// Reset empties the store and sets k_rank to one; no clearing pass is needed.
// A stalled result holds back the next point that asks for a report; the queue keeps the
// front accepting until the queue fills.
`include "running_kth_nearest_point_defines.svh"

module running_kth_nearest_point (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  rkn_pkg::in_t                    in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output rkn_pkg::out_t                   out_data_o,
  input  logic                            cfg_we_i,
  input  logic [rkn_pkg::RANK_BITS-1:0]   cfg_wdata_i
);
  import rkn_pkg::*;

  logic [RANK_BITS-1:0] k_rank_q;
  logic [CNT_BITS-1:0]  k_eff;
  logic                 push, pop;
  entry_t               push_data, head;
  fifo_stat_t           fifo_stat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_rank_q <= RANK_BITS'(1);
    end else if (cfg_we_i) begin
      k_rank_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (k_rank_q == '0) begin
      k_eff = CNT_BITS'(1);
    end else if (int'(k_rank_q) > MAX_RANK) begin
      k_eff = CNT_BITS'(MAX_RANK);
    end else begin
      k_eff = CNT_BITS'(k_rank_q);
    end
  end

  rkn_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .fifo_stat_i (fifo_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  rkn_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (fifo_stat)
  );

  rkn_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .k_eff_i     (k_eff),
    .head_i      (head),
    .fifo_stat_i (fifo_stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  `RKN_ASSERT_NOW(a_stall_only_when_full, in_stall_o, fifo_stat.full)
  `RKN_ASSERT_NOW(a_no_pop_when_empty, fifo_stat.empty, !pop)
  `RKN_ASSERT_NOW(a_invalid_result_zero, out_valid_o && !out_data_o.result_valid,
                  (out_data_o.kth_x == '0) && (out_data_o.kth_y == '0))
  `RKN_ASSERT_NEXT(a_rank_write_taken, cfg_we_i, k_rank_q == $past(cfg_wdata_i))

endmodule
